// ----- sv/stte_pkg.sv -----
// ----------------------------------------------------------------------------
// stte_pkg: shared types and constants for the taint tag engine
// Command codes, register indexes, field widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package stte_pkg;

  localparam int ADDR_W     = 32;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TAG_W      = 8;
  localparam int BYTE_SHIFT = 3;          // eight tag bits per tag byte
  localparam logic [BYTE_SHIFT-1:0] BIT_MASK = 3'h7;

  // Commands
  localparam logic [CMD_W-1:0] CMD_COPY = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REG  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAM_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERI_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERI_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_SIZE = 3'd4;

  // Controller -> datapath
  typedef struct packed {
    logic clear;   // write zero at the sweep pointer
    logic load;    // capture an input beat
    logic look;    // read tags, evaluate windows and list
    logic exec;    // update tags and run state, load result
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_done;  // sweep pointer at last tag byte
    logic out_free;    // result register can take a new beat
  } dp_stat_t;

endpackage

// ----- sv/stte_in_if.sv -----
// ----------------------------------------------------------------------------
// stte_in_if: input item channel
// One beat carries one byte of a tag operation.
// ----------------------------------------------------------------------------
interface stte_in_if import stte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] target_address;
  logic [ADDR_W-1:0] source_address;
  logic              tag_value;
  logic              first_of_run;
  logic              last_of_run;

  modport source (
    output valid, command, target_address, source_address, tag_value,
           first_of_run, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, command, target_address, source_address, tag_value,
           first_of_run, last_of_run,
    output ready
  );
endinterface

// ----- sv/stte_out_if.sv -----
// ----------------------------------------------------------------------------
// stte_out_if: result channel
// One beat per accepted input beat.
// ----------------------------------------------------------------------------
interface stte_out_if import stte_pkg::*; ();
  logic valid;
  logic ready;
  logic verdict;
  logic done_res;
  logic out_of_window;

  modport source (output valid, verdict, done_res, out_of_window, input ready);
  modport sink (input valid, verdict, done_res, out_of_window, output ready);
endinterface

// ----- sv/stte_cfg_if.sv -----
// ----------------------------------------------------------------------------
// stte_cfg_if: configuration write channel
// Register index plus write data.
// ----------------------------------------------------------------------------
interface stte_cfg_if import stte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/stte_ctrl.sv -----
// ----------------------------------------------------------------------------
// stte_ctrl: sequencing state machine
// Clear sweep after reset, then load / look / exec per input beat.
// ----------------------------------------------------------------------------
module stte_ctrl import stte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl.look  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register has room
        if (stat.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> stat.out_free)
    else $error("exec issued while result register full");

  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !stat.clear_done) |=> state_r == ST_CLEAR)
    else $error("left clear sweep early");

  a_look_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> ctl.look ##1 (state_r == ST_EXEC))
    else $error("load not followed by look and exec");

endmodule

// ----- sv/stte_dp.sv -----
// ----------------------------------------------------------------------------
// stte_dp: tag memory, peripheral list, run state and result register
// Tag memory has one write port and two registered read ports.
// ----------------------------------------------------------------------------
module stte_dp import stte_pkg::*; #(
  parameter int TAG_ADDR_BITS    = 16,
  parameter int PERIPHERAL_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              ctl,
  output dp_stat_t              stat,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input payload
  input  logic [CMD_W-1:0]      in_command,
  input  logic [ADDR_W-1:0]     in_target_address,
  input  logic [ADDR_W-1:0]     in_source_address,
  input  logic                  in_tag_value,
  input  logic                  in_first_of_run,
  input  logic                  in_last_of_run,
  // result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_verdict,
  output logic                  out_done_res,
  output logic                  out_out_of_window
);

  localparam int IDX_W   = TAG_ADDR_BITS - BYTE_SHIFT;
  localparam int DEPTH   = 1 << IDX_W;
  localparam int CNT_W   = $clog2(PERIPHERAL_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(PERIPHERAL_SLOTS);

  // configuration registers
  logic [ADDR_W-1:0] ram_base_r, peri_base_r, peri_size_r, flash_base_r, flash_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r   <= '0;
      peri_base_r  <= '0;
      peri_size_r  <= '0;
      flash_base_r <= '0;
      flash_size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAM_BASE:   ram_base_r   <= cfg_data;
        REG_PERI_BASE:  peri_base_r  <= cfg_data;
        REG_PERI_SIZE:  peri_size_r  <= cfg_data;
        REG_FLASH_BASE: flash_base_r <= cfg_data;
        REG_FLASH_SIZE: flash_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  logic [CMD_W-1:0]  cmd_r;
  logic [ADDR_W-1:0] tgt_r, src_r;
  logic              tv_r, first_r, last_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_command;
      tgt_r   <= in_target_address;
      src_r   <= in_source_address;
      tv_r    <= in_tag_value;
      first_r <= in_first_of_run;
      last_r  <= in_last_of_run;
    end
  end

  // look stage: offsets, windows, list match
  logic [ADDR_W-1:0]     tgt_off, src_off;
  logic [IDX_W-1:0]      tgt_idx, src_idx;
  logic                  peri_hit, flash_hit, list_match;
  logic [ADDR_W:0]       peri_top, flash_top;

  logic [IDX_W-1:0]      tgt_idx_r;
  logic [BYTE_SHIFT-1:0] tgt_bit_r, src_bit_r;
  logic                  tgt_ram_r, src_ram_r, peri_hit_r, flash_hit_r, list_match_r;

  logic [ADDR_W-1:0]     list_r [PERIPHERAL_SLOTS];
  logic [CNT_W-1:0]      per_cnt_r, per_cnt_nxt;

  always_comb begin
    tgt_off   = tgt_r - ram_base_r;
    src_off   = src_r - ram_base_r;
    tgt_idx   = tgt_off[TAG_ADDR_BITS-1:BYTE_SHIFT];
    src_idx   = src_off[TAG_ADDR_BITS-1:BYTE_SHIFT];
    // bounds inclusive, sum taken one bit wider so it cannot wrap
    peri_top  = {1'b0, peri_base_r} + {1'b0, peri_size_r};
    flash_top = {1'b0, flash_base_r} + {1'b0, flash_size_r};
    peri_hit  = (tgt_r >= peri_base_r) && ({1'b0, tgt_r} <= peri_top);
    flash_hit = (tgt_r >= flash_base_r) && ({1'b0, tgt_r} <= flash_top);
    list_match = 1'b0;
    for (int i = 0; i < PERIPHERAL_SLOTS; i++) begin
      if ((CNT_W'(i) < per_cnt_r) && (list_r[i] == tgt_r)) list_match = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      tgt_idx_r    <= tgt_idx;
      tgt_bit_r    <= tgt_off[BYTE_SHIFT-1:0] & BIT_MASK;
      src_bit_r    <= src_off[BYTE_SHIFT-1:0] & BIT_MASK;
      tgt_ram_r    <= (tgt_off[ADDR_W-1:TAG_ADDR_BITS] == '0);
      src_ram_r    <= (src_off[ADDR_W-1:TAG_ADDR_BITS] == '0);
      peri_hit_r   <= peri_hit;
      flash_hit_r  <= flash_hit;
      list_match_r <= list_match;
    end
  end

  // tag memory
  logic [TAG_W-1:0] tag_mem [DEPTH];
  logic [TAG_W-1:0] rd_t_r, rd_s_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [TAG_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[mem_waddr] <= mem_wdata;
    if (ctl.look) begin
      rd_t_r <= tag_mem[tgt_idx];
      rd_s_r <= tag_mem[src_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         clr_idx_r <= '0;
    else if (ctl.clear) clr_idx_r <= clr_idx_r + 1'b1;
  end

  // exec stage
  logic             run_verdict_r, run_verdict_nxt;
  logic             run_decided_r, run_decided_nxt;
  logic             verdict, oow, tag_we, new_tag, list_we;
  logic             old_tag, src_tag;
  logic [TAG_W-1:0] bit_sel;

  always_comb begin
    old_tag = rd_t_r[tgt_bit_r];
    src_tag = rd_s_r[src_bit_r];
    bit_sel = TAG_W'(1) << tgt_bit_r;

    run_verdict_nxt = run_verdict_r;
    run_decided_nxt = run_decided_r;
    per_cnt_nxt     = per_cnt_r;
    verdict = 1'b0;
    oow     = 1'b0;
    tag_we  = 1'b0;
    new_tag = 1'b0;
    list_we = 1'b0;

    if ((cmd_r inside {[CMD_COPY:CMD_MARK]}) && first_r) begin
      run_verdict_nxt = 1'b0;
      run_decided_nxt = 1'b0;
    end

    case (cmd_r)
      CMD_COPY: begin
        if (tgt_ram_r && src_ram_r) begin
          tag_we  = 1'b1;
          new_tag = src_tag;
          run_verdict_nxt = run_verdict_nxt | src_tag | old_tag;
        end else begin
          oow = 1'b1;
        end
        verdict = run_verdict_nxt;
      end
      CMD_FILL: begin
        if (tgt_ram_r) begin
          tag_we  = 1'b1;
          new_tag = tv_r;
          run_verdict_nxt = run_verdict_nxt | tv_r | old_tag;
        end else begin
          oow = 1'b1;
        end
        verdict = run_verdict_nxt;
      end
      CMD_READ: begin
        if (!run_decided_nxt) begin
          if (first_r && peri_hit_r) begin
            run_verdict_nxt = list_match_r;
            run_decided_nxt = 1'b1;
          end else if (first_r && flash_hit_r) begin
            run_verdict_nxt = 1'b0;
            run_decided_nxt = 1'b1;
          end else if (tgt_ram_r) begin
            run_verdict_nxt = run_verdict_nxt | old_tag;
          end else begin
            oow = 1'b1;
          end
        end
        verdict = run_verdict_nxt;
      end
      CMD_MARK: begin
        if (tgt_ram_r) begin
          tag_we  = 1'b1;
          new_tag = 1'b1;
        end else begin
          oow = 1'b1;
        end
        verdict = run_verdict_nxt;
      end
      CMD_REG: begin
        if (per_cnt_r < SLOTS) begin
          list_we     = 1'b1;
          per_cnt_nxt = per_cnt_r + 1'b1;
          verdict     = 1'b1;
        end
      end
      default: ;
    endcase

    mem_we    = ctl.clear | (ctl.exec & tag_we);
    mem_waddr = ctl.clear ? clr_idx_r : tgt_idx_r;
    mem_wdata = ctl.clear ? '0 : (new_tag ? (rd_t_r | bit_sel) : (rd_t_r & ~bit_sel));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_verdict_r <= 1'b0;
      run_decided_r <= 1'b0;
      per_cnt_r     <= '0;
    end else if (ctl.exec) begin
      run_verdict_r <= run_verdict_nxt;
      run_decided_r <= run_decided_nxt;
      per_cnt_r     <= per_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && list_we) begin
      for (int i = 0; i < PERIPHERAL_SLOTS; i++) begin
        if (per_cnt_r == CNT_W'(i)) list_r[i] <= tgt_r;
      end
    end
  end

  // result register
  logic out_valid_r;
  logic verdict_r, done_r, oow_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                    out_valid_r <= 1'b0;
    else if (ctl.exec)             out_valid_r <= 1'b1;
    else if (out_ready)            out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      verdict_r <= verdict;
      done_r    <= last_r;
      oow_r     <= oow;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = verdict_r;
  assign out_done_res      = done_r;
  assign out_out_of_window = oow_r;

  assign stat.clear_done = (clr_idx_r == {IDX_W{1'b1}});
  assign stat.out_free   = !out_valid_r || out_ready;

  a_valid_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.exec))
    else $error("result appeared without exec");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    per_cnt_r <= SLOTS)
    else $error("peripheral count beyond slots");

  a_no_write_on_look: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.look |-> !mem_we)
    else $error("tag write collides with tag read");

endmodule

// ----- sv/shadow_taint_tag_engine.sv -----
// ----------------------------------------------------------------------------
// shadow_taint_tag_engine: byte-granular taint shadow bitmap
// One tag bit per tracked RAM byte, with run verdicts for copy, fill and read.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the tag memory to zero, one tag byte per
// cycle; no input beat is taken during the sweep, while configuration
// writes are taken at any time (cfg ready is tied high). Each input beat
// then passes capture, a look step that reads the target and source tag
// bytes from the tag memory (registered read) and evaluates the RAM,
// peripheral and flash windows and the peripheral list, and an exec step
// that writes the updated tag byte back, updates the run verdict and loads
// the result register. The next beat is accepted in the cycle after exec,
// even while the previous result still waits; exec stalls only while the
// result register is full and not being drained. Items do not overlap: a
// new one is taken only after the previous one has left exec, because of
// the single read-modify-write of the tag memory per item.
// Configuration may only change while no item is in flight.
// ----------------------------------------------------------------------------
module shadow_taint_tag_engine import stte_pkg::*; #(
  parameter int TAG_ADDR_BITS    = 16,  // log2 of tracked RAM window in bytes
  parameter int PERIPHERAL_SLOTS = 8    // peripheral address list entries
) (
  input  logic       clk,
  input  logic       rst_n,
  stte_in_if.sink    in_ch,
  stte_out_if.source out_ch,
  stte_cfg_if.sink   cfg_ch
);

  ctl_cmd_t ctl;
  dp_stat_t stat;
  logic     in_ready;

  // config port never stalls
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  stte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  stte_dp #(
    .TAG_ADDR_BITS    (TAG_ADDR_BITS),
    .PERIPHERAL_SLOTS (PERIPHERAL_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .cfg_we            (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .in_command        (in_ch.command),
    .in_target_address (in_ch.target_address),
    .in_source_address (in_ch.source_address),
    .in_tag_value      (in_ch.tag_value),
    .in_first_of_run   (in_ch.first_of_run),
    .in_last_of_run    (in_ch.last_of_run),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_verdict       (out_ch.verdict),
    .out_done_res      (out_ch.done_res),
    .out_out_of_window (out_ch.out_of_window)
  );

endmodule
